/* rtl/core/efrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efrs_pkg
// Shared types and constants for the register slave with an event queue.
// ----------------------------------------------------------------------------
package efrs_pkg;

   localparam int DEF_QUEUE_DEPTH    = 16;
   localparam int DEF_MAX_ENTRIES    = 15;
   localparam int DEF_NUM_INDICATORS = 11;

   localparam int CNT_W   = 5;
   localparam int WORD_W  = 16;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   localparam logic [7:0] ADDR_LED   = 8'h0A;
   localparam logic [7:0] ADDR_EVENT = 8'h0B;
   localparam logic [7:0] ADDR_ID    = 8'h0C;
   localparam logic [7:0] ADDR_HW    = 8'h0D;

   localparam logic [CSR_IDX_W-1:0] CSR_PRODUCT_ID = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SW_VERSION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HW_VERSION = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] event_kind;
      logic [7:0] event_value;
      logic [7:0] reg_select;
      logic [1:0] data_count;
      logic [7:0] low_byte;
      logic [7:0] high_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] read_word;
      logic        irq_asserted;
      logic [15:0] led_states;
      logic [15:0] led_mask;
      logic        event_dropped;
   } rsp_type;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic [WORD_W-1:0] push_data;
   } queue_ctrl_type;

   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic [WORD_W-1:0] head_data;
   } queue_status_type;

endpackage

/* rtl/core/efrs_event_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efrs_event_queue
// Circular event store in a synchronous memory with registered head read.
// ----------------------------------------------------------------------------
module efrs_event_queue
   import efrs_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_ctrl_type   ctrl,
   output queue_status_type status
);

   localparam int IDX_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

   logic [WORD_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [WORD_W-1:0] head_ff;
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]  count;

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem_ff[wr_idx_ff] <= ctrl.push_data;
      end
      head_ff <= mem_ff[rd_idx_ff];
   end

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      if (ctrl.push) begin
         wr_idx_in = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
      end
      if (ctrl.pop) begin
         rd_idx_in = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   assign count = CNT_W'(wr_idx_ff) - CNT_W'(rd_idx_ff)
                  + ((wr_idx_ff < rd_idx_ff) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(0));

   assign status.count     = count;
   assign status.head_data = head_ff;

endmodule

/* rtl/core/event_fifo_register_slave_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_fifo_register_slave_unit
// Register slave with LED word, ID and version registers and an event queue.
// ----------------------------------------------------------------------------
// Flow: a request is registered into the item register and executes in ST_EXEC,
// where its result is registered into the response register. No new request is
// taken until the item has executed; the queue head is registered from the event memory.
// Reset: synchronous, clears queue pointers, address, LED word, interrupt
// and configuration; event memory contents are not cleared.
module event_fifo_register_slave_unit
   import efrs_pkg::*;
#(
   parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH,
   parameter int MAX_ENTRIES    = DEF_MAX_ENTRIES,
   parameter int NUM_INDICATORS = DEF_NUM_INDICATORS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   localparam int LIMIT = (MAX_ENTRIES < QUEUE_DEPTH - 1) ? MAX_ENTRIES : QUEUE_DEPTH - 1;
   localparam int LOW_N = NUM_INDICATORS - 2;
   localparam logic [16:0] MASK_LO_W = (17'd1 << LOW_N) - 17'd1;
   localparam logic [16:0] MASK_HI_W = (17'd1 << (LOW_N + 2)) - 17'd1;
   localparam logic [15:0] MASK_LO = MASK_LO_W[15:0];
   localparam logic [15:0] MASK_HI = MASK_HI_W[15:0];

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   req_type          item_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       address_ff, address_in;
   logic [15:0]      led_ff, led_in;
   logic             irq_ff, irq_in;
   logic [7:0]       product_id_ff;
   logic [7:0]       sw_version_ff;
   logic [15:0]      hw_version_ff;
   logic             req_xfer;
   logic             exec_go;
   queue_ctrl_type   q_ctrl;
   queue_status_type q_status;
   logic [15:0]      word;

   efrs_event_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (q_ctrl),
      .status (q_status)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign exec_go   = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      address_in   = address_ff;
      led_in       = led_ff;
      irq_in       = irq_ff;
      q_ctrl       = '0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      word         = (item_ff.data_count == 2'd1) ? {8'h00, item_ff.low_byte}
                                                 : {item_ff.high_byte, item_ff.low_byte};
      if (req_xfer) begin
         state_in = ST_EXEC;
      end
      if (exec_go) begin
         state_in = ST_IDLE;
         rsp_in.read_word     = '0;
         rsp_in.event_dropped = 1'b0;
         unique case (action_type'(item_ff.action))
            ACT_ADD: begin
               if (q_status.count < CNT_W'(LIMIT)) begin
                  q_ctrl.push      = 1'b1;
                  q_ctrl.push_data = {item_ff.event_kind, item_ff.event_value};
                  irq_in           = 1'b1;
               end else begin
                  rsp_in.event_dropped = 1'b1;
               end
            end
            ACT_WRITE: begin
               address_in = item_ff.reg_select;
               if (item_ff.data_count != 2'd0 && item_ff.reg_select == ADDR_LED) begin
                  led_in = word;
               end
            end
            ACT_READ: begin
               priority if (address_ff == ADDR_ID) begin
                  rsp_in.read_word = {product_id_ff, sw_version_ff};
                  irq_in           = 1'b0;
               end else if (address_ff == ADDR_HW) begin
                  rsp_in.read_word = hw_version_ff;
                  irq_in           = 1'b0;
               end else if (address_ff == ADDR_LED) begin
                  rsp_in.read_word = led_ff;
               end else if (address_ff == ADDR_EVENT) begin
                  if (q_status.count != '0) begin
                     rsp_in.read_word = q_status.head_data
                                        | {q_status.count[3:0], 12'h000};
                     q_ctrl.pop       = 1'b1;
                  end
                  if (q_status.count <= CNT_W'(1)) begin
                     irq_in = 1'b0;
                  end
               end else begin
                  rsp_in.read_word = '0;
               end
            end
            default: begin
               rsp_in.read_word = '0;
            end
         endcase
         rsp_in.irq_asserted = irq_in;
         rsp_in.led_states   = led_in;
         rsp_in.led_mask     = led_in[15] ? MASK_HI : MASK_LO;
         rsp_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         address_ff    <= '0;
         led_ff        <= '0;
         irq_ff        <= 1'b0;
         product_id_ff <= '0;
         sw_version_ff <= '0;
         hw_version_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         address_ff   <= address_in;
         led_ff       <= led_in;
         irq_ff       <= irq_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PRODUCT_ID) begin
               product_id_ff <= csr_data[7:0];
            end
            if (csr_index == CSR_SW_VERSION) begin
               sw_version_ff <= csr_data[7:0];
            end
            if (csr_index == CSR_HW_VERSION) begin
               hw_version_ff <= csr_data;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      q_status.count <= CNT_W'(LIMIT))
      else $error("event queue holds more than the limit");

   assert property (@(posedge clock) disable iff (reset)
      exec_go && q_ctrl.push |=> q_status.count == $past(q_status.count) + 1'b1)
      else $error("push did not grow the queue");

   assert property (@(posedge clock) disable iff (reset)
      exec_go && q_ctrl.pop |=> rsp_ff.read_word[15:12] != 4'd0)
      else $error("event read lost its count");

   assert property (@(posedge clock) disable iff (reset)
      exec_go && q_ctrl.push |=> rsp_ff.irq_asserted && irq_ff)
      else $error("accepted event did not raise the interrupt");
`endif

endmodule
